// ----- design/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probing hash table
// Request codes, field widths and the layout of one table entry.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int HASH_W  = 32;
    localparam int SIZE_W  = 11;
    localparam int SLOT_W  = 10;
    localparam int HBIT_W  = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

endpackage

// ----- design/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open addressing hash table with linear probing
// Insert, lookup, remove and clear over a single port table memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its single
// result appears on success, data_out and slot_index for the one cycle in
// which done is high; the receiver cannot stall it. The home slot is found by
// a bit-serial remainder unit, one hash bit per cycle. Each probed slot is
// then read from the table memory into its output register and then compared.
// A clear walks all CAPACITY entries, one per cycle, and the same walk runs
// after reset, during which busy is high and no request is taken. The table
// size may be written only while busy is low and no result is pending.
module linear_probe_hash_table #(
    parameter int CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [lpht_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [lpht_pkg::KEY_W-1:0]   key,
    input  logic [lpht_pkg::HASH_W-1:0]  hash_value,
    input  logic [lpht_pkg::DATA_W-1:0]  data_in,
    output logic                         done,
    output logic                         success,
    output logic [lpht_pkg::DATA_W-1:0]  data_out,
    output logic [lpht_pkg::SLOT_W-1:0]  slot_index
);

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (IDX_W + 1 > lpht_pkg::SIZE_W) ? IDX_W + 1 : lpht_pkg::SIZE_W;
    localparam logic [16:0] CAP_V = 17'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [lpht_pkg::SIZE_W-1:0]  size_reg;
    logic [lpht_pkg::SIZE_W-1:0]  live_n;
    logic [lpht_pkg::SIZE_W-1:0]  n_reg, n_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [lpht_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [lpht_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [lpht_pkg::HASH_W-1:0]  hash_reg, hash_next;
    logic [lpht_pkg::SIZE_W-1:0]  rem_reg, rem_next;
    logic [lpht_pkg::SIZE_W:0]    rem_trial;
    logic [lpht_pkg::SIZE_W-1:0]  rem_new;
    logic [lpht_pkg::HBIT_W-1:0]  bit_reg, bit_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [IDX_W:0]               idx_inc;
    logic [IDX_W-1:0]             idx_wrap;
    logic [lpht_pkg::SIZE_W-1:0]  cnt_reg, cnt_next;
    logic                         sweep_req_reg, sweep_req_next;
    logic                         done_reg, done_next;
    logic                         success_reg, success_next;
    logic [lpht_pkg::DATA_W-1:0]  dout_reg, dout_next;
    logic [lpht_pkg::SLOT_W-1:0]  slot_reg, slot_next;

    lpht_pkg::entry_t             mem [CAPACITY];
    lpht_pkg::entry_t             rd_reg;
    lpht_pkg::entry_t             wr_entry;
    logic                         mem_we;
    logic                         mem_re;
    logic                         key_hit;
    logic                         last_step;

    always_comb
    begin
        if (size_reg == '0)
        begin
            live_n = lpht_pkg::SIZE_W'(1);
        end
        else if ({6'b0, size_reg} > CAP_V)
        begin
            live_n = lpht_pkg::SIZE_W'(CAP_V);
        end
        else
        begin
            live_n = size_reg;
        end
    end

    assign rem_trial = {rem_reg, hash_reg[lpht_pkg::HASH_W-1]};
    assign rem_new   = (rem_trial >= {1'b0, n_reg})
                     ? lpht_pkg::SIZE_W'(rem_trial - {1'b0, n_reg})
                     : lpht_pkg::SIZE_W'(rem_trial);

    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign idx_wrap  = (CMP_W'(idx_inc) >= CMP_W'(n_reg)) ? '0 : idx_inc[IDX_W-1:0];
    assign key_hit   = (rd_reg.key == key_reg);
    assign last_step = ((cnt_reg + 1'b1) == n_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        hash_next      = hash_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        sweep_req_next = sweep_req_reg;
        done_next      = 1'b0;
        success_next   = success_reg;
        dout_next      = dout_reg;
        slot_next      = slot_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_entry       = '{used: 1'b0, key: key_reg, data: data_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = req_type;
                    key_next  = key;
                    data_next = data_in;
                    hash_next = hash_value;
                    n_next    = live_n;
                    rem_next  = '0;
                    bit_next  = '0;
                    cnt_next  = '0;
                    if (req_type == lpht_pkg::REQ_CLEAR)
                    begin
                        idx_next       = '0;
                        sweep_req_next = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SWEEP:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                    if (sweep_req_reg)
                    begin
                        done_next    = 1'b1;
                        success_next = 1'b0;
                        dout_next    = '0;
                        slot_next    = '0;
                    end
                    sweep_req_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                rem_next  = rem_new;
                hash_next = {hash_reg[lpht_pkg::HASH_W-2:0], 1'b0};
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == '1)
                begin
                    idx_next   = IDX_W'(rem_new);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (kind_reg == lpht_pkg::REQ_INSERT && !rd_reg.used)
                begin
                    mem_we       = 1'b1;
                    wr_entry     = '{used: 1'b1, key: key_reg, data: data_reg};
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    dout_next    = '0;
                    slot_next    = lpht_pkg::SLOT_W'(idx_reg);
                    state_next   = S_IDLE;
                end
                else if (kind_reg == lpht_pkg::REQ_LOOKUP && rd_reg.used && key_hit)
                begin
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    dout_next    = rd_reg.data;
                    slot_next    = lpht_pkg::SLOT_W'(idx_reg);
                    state_next   = S_IDLE;
                end
                else if (kind_reg == lpht_pkg::REQ_REMOVE && rd_reg.used && key_hit)
                begin
                    mem_we       = 1'b1;
                    wr_entry     = '{used: 1'b0, key: rd_reg.key, data: rd_reg.data};
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    dout_next    = '0;
                    slot_next    = lpht_pkg::SLOT_W'(idx_reg);
                    state_next   = S_IDLE;
                end
                else if ((kind_reg == lpht_pkg::REQ_LOOKUP && !rd_reg.used) || last_step)
                begin
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    dout_next    = '0;
                    slot_next    = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_wrap;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            size_reg      <= lpht_pkg::SIZE_RESET;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            sweep_req_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            bit_reg       <= bit_next;
            sweep_req_reg <= sweep_req_next;
            done_reg      <= done_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        data_reg    <= data_next;
        hash_reg    <= hash_next;
        rem_reg     <= rem_next;
        success_reg <= success_next;
        dout_reg    <= dout_next;
        slot_reg    <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign success    = success_reg;
    assign data_out   = dout_reg;
    assign slot_index = slot_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe raised while the block is still busy.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not make the block busy.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |-> (data_out == '0 && slot_index == '0))
        else $error("Failed request returned nonzero data or slot.");

    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_RD))
        else $error("Compare step entered without a preceding table read.");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (cnt_reg < n_reg && CMP_W'(idx_reg) < CMP_W'(n_reg)))
        else $error("Probe went beyond the live table size.");

endmodule

// ----- tb/lpht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker: result checker for the linear probing hash table
// Watches the configuration port and each request and result transfer. It
// keeps its own copy of the slots and the table size, works out the reply to
// every accepted request, and compares each reply strobe, field by field,
// with the oldest reply still owed.
// ----------------------------------------------------------------------------
module lpht_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lpht_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [lpht_pkg::KEY_W-1:0]  key,
    input  logic [lpht_pkg::HASH_W-1:0] hash_value,
    input  logic [lpht_pkg::DATA_W-1:0] data_in,
    input  logic                        done,
    input  logic                        success,
    input  logic [lpht_pkg::DATA_W-1:0] data_out,
    input  logic [lpht_pkg::SLOT_W-1:0] slot_index,
    output int                          mismatch_count,
    output int                          replies_owed
);

    typedef struct packed {
        logic                        hit;
        logic [lpht_pkg::DATA_W-1:0] data;
        logic [lpht_pkg::SLOT_W-1:0] slot;
    } reply_t;

    logic                        slot_used [CAPACITY];
    logic [lpht_pkg::KEY_W-1:0]  slot_key  [CAPACITY];
    logic [lpht_pkg::DATA_W-1:0] slot_data [CAPACITY];
    logic [lpht_pkg::SIZE_W-1:0] size_reg;
    reply_t                      expected_replies [$];

    task automatic report(input string field, input logic [lpht_pkg::DATA_W-1:0] want,
                          input logic [lpht_pkg::DATA_W-1:0] got);
        $display("MISMATCH %s: expected %0h, got %0h at %0t ns", field, want, got, $time);
        mismatch_count++;
    endtask

    function automatic reply_t probe_table(input logic [1:0] kind,
                                           input logic [lpht_pkg::KEY_W-1:0] k,
                                           input logic [lpht_pkg::HASH_W-1:0] h,
                                           input logic [lpht_pkg::DATA_W-1:0] d);
        int unsigned n;
        int unsigned idx;
        reply_t      r;
        r   = '0;
        n   = (size_reg == 0) ? 1 : ((size_reg > CAPACITY) ? CAPACITY : size_reg);
        idx = h % n;
        if (kind == lpht_pkg::REQ_CLEAR)
        begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
        end
        else
        begin
            for (int unsigned s = 0; s < n; s++)
            begin
                if (kind == lpht_pkg::REQ_INSERT && !slot_used[idx])
                begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx]  = k;
                    slot_data[idx] = d;
                    r.hit  = 1'b1;
                    r.slot = idx[lpht_pkg::SLOT_W-1:0];
                    break;
                end
                if (kind == lpht_pkg::REQ_LOOKUP)
                begin
                    if (!slot_used[idx])
                        break;
                    if (slot_key[idx] == k)
                    begin
                        r.hit  = 1'b1;
                        r.data = slot_data[idx];
                        r.slot = idx[lpht_pkg::SLOT_W-1:0];
                        break;
                    end
                end
                if (kind == lpht_pkg::REQ_REMOVE && slot_used[idx] && slot_key[idx] == k)
                begin
                    slot_used[idx] = 1'b0;
                    r.hit  = 1'b1;
                    r.slot = idx[lpht_pkg::SLOT_W-1:0];
                    break;
                end
                idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
        end
        return r;
    endfunction

    initial
    begin
        mismatch_count = 0;
        replies_owed   = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            size_reg = lpht_pkg::SIZE_RESET;
            expected_replies.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    report("unexpected reply", '0,
                           {success, data_out[lpht_pkg::DATA_W-2:0]});
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (success !== want.hit)
                        report("success", want.hit, success);
                    if (data_out !== want.data)
                        report("data_out", want.data, data_out);
                    if (slot_index !== want.slot)
                        report("slot_index", want.slot, slot_index);
                end
            end
            if (start && !busy)
                expected_replies.push_back(probe_table(req_type, key, hash_value, data_in));
            if (cfg_wr_en)
                size_reg = cfg_wr_data;
        end
        replies_owed <= expected_replies.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the linear probing hash table
// Drives a directed set of inserts, lookups, removes and clears over the
// size extremes, then random phases of requests over a small pool of keys,
// each phase at a new table size, with random gaps between request transfers.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY    = 1024;
    localparam int TOTAL_ITEMS = 1500;
    localparam int CALM_ITEMS  = 150;
    localparam int CYCLE_LIMIT = 16000000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [lpht_pkg::SIZE_W-1:0] cfg_wr_data;
    logic                        start;
    logic                        busy;
    logic [1:0]                  req_type;
    logic [lpht_pkg::KEY_W-1:0]  key;
    logic [lpht_pkg::HASH_W-1:0] hash_value;
    logic [lpht_pkg::DATA_W-1:0] data_in;
    logic                        done;
    logic                        success;
    logic [lpht_pkg::DATA_W-1:0] data_out;
    logic [lpht_pkg::SLOT_W-1:0] slot_index;
    int                          mismatch_count;
    int                          replies_owed;
    int                          cycle_count;
    int                          items_sent;

    logic [lpht_pkg::KEY_W-1:0]  pool_key  [8];
    logic [lpht_pkg::HASH_W-1:0] pool_hash [8];

    linear_probe_hash_table #(.CAPACITY(CAPACITY)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .start(start), .busy(busy),
        .req_type(req_type), .key(key), .hash_value(hash_value), .data_in(data_in),
        .done(done), .success(success), .data_out(data_out), .slot_index(slot_index)
    );

    lpht_checker #(.CAPACITY(CAPACITY)) result_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .start(start), .busy(busy),
        .req_type(req_type), .key(key), .hash_value(hash_value), .data_in(data_in),
        .done(done), .success(success), .data_out(data_out), .slot_index(slot_index),
        .mismatch_count(mismatch_count), .replies_owed(replies_owed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial cycle_count = 0;
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send(input logic [1:0] kind, input logic [lpht_pkg::KEY_W-1:0] k,
                        input logic [lpht_pkg::HASH_W-1:0] h,
                        input logic [lpht_pkg::DATA_W-1:0] d);
        @(negedge clk);
        req_type   = kind;
        key        = k;
        hash_value = h;
        data_in    = d;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause(input int cycles);
        @(negedge clk);
        start      = 1'b0;
        req_type   = 2'($urandom);
        key        = $urandom;
        hash_value = $urandom;
        data_in    = $urandom;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic write_size(input logic [lpht_pkg::SIZE_W-1:0] value);
        @(negedge clk);
        start = 1'b0;
        while (replies_owed != 0 || busy)
            @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = lpht_pkg::SIZE_W'($urandom);
    endtask

    initial
    begin
        int                          phase;
        int                          phase_items;
        int                          pick;
        int                          slot;
        logic [1:0]                  kind;
        logic [lpht_pkg::HASH_W-1:0] h;
        logic [lpht_pkg::SIZE_W-1:0] size;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        start       = 1'b0;
        req_type    = lpht_pkg::REQ_INSERT;
        key         = '0;
        hash_value  = '0;
        data_in     = '0;
        items_sent  = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send(lpht_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send(lpht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(lpht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send(lpht_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0005, 32'h0000_0000);
        send(lpht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send(lpht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send(lpht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send(lpht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send(lpht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send(lpht_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send(lpht_pkg::REQ_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send(lpht_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        write_size('0);
        send(lpht_pkg::REQ_INSERT, 32'hCAFE_0001, 32'hDEAD_BEEF, 32'h5A5A_A5A5);
        send(lpht_pkg::REQ_INSERT, 32'hCAFE_0002, 32'h0000_0007, 32'h0000_0001);
        send(lpht_pkg::REQ_LOOKUP, 32'hCAFE_0001, 32'h0000_0003, 32'h0000_0000);

        write_size(11'h7FF);
        send(lpht_pkg::REQ_INSERT, 32'h8000_0000, 32'd1500, 32'h8000_0001);
        send(lpht_pkg::REQ_LOOKUP, 32'h8000_0000, 32'd1500, 32'h0000_0000);

        write_size(11'd4);
        send(lpht_pkg::REQ_CLEAR, 32'h0, 32'h0, 32'h0);
        for (int i = 1; i <= 5; i++)
            send(lpht_pkg::REQ_INSERT, 32'h100 + i, 32'h0, 32'h200 + i);
        write_size(11'd2);
        send(lpht_pkg::REQ_LOOKUP, 32'h104, 32'h3, 32'h0);
        write_size(11'd4);
        send(lpht_pkg::REQ_LOOKUP, 32'h104, 32'h3, 32'h0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            phase++;
            if (phase % 8 == 3)
            begin
                pick        = $urandom_range(0, 2);
                size        = (pick == 0) ? 11'd1024 : (pick == 1) ? 11'h7FF
                            : lpht_pkg::SIZE_W'($urandom_range(512, 1024));
                phase_items = 20;
            end
            else
            begin
                size        = ($urandom_range(0, 3) == 0)
                            ? lpht_pkg::SIZE_W'($urandom_range(0, 4))
                            : lpht_pkg::SIZE_W'($urandom_range(5, 64));
                phase_items = 60;
            end
            write_size(size);
            for (int i = 0; i < 8; i++)
            begin
                pool_key[i]  = $urandom;
                pool_hash[i] = (i > 0 && $urandom_range(0, 3) == 0) ? pool_hash[0] : $urandom;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                pool_key[0] = 32'h0000_0000;
                pool_key[1] = 32'hFFFF_FFFF;
            end
            if ($urandom_range(0, 1) == 0)
                send(lpht_pkg::REQ_CLEAR, $urandom, $urandom, $urandom);
            for (int i = 0; i < phase_items && items_sent < TOTAL_ITEMS; i++)
            begin
                if (items_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 11));
                pick = $urandom_range(0, 99);
                slot = $urandom_range(0, 7);
                h    = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[slot];
                if (pick < 8)
                begin
                    send(2'($urandom), $urandom, $urandom, $urandom);
                end
                else if (pick < 11)
                begin
                    send(lpht_pkg::REQ_CLEAR, $urandom, $urandom, $urandom);
                end
                else
                begin
                    kind = (pick < 50) ? lpht_pkg::REQ_INSERT
                         : (pick < 75) ? lpht_pkg::REQ_LOOKUP : lpht_pkg::REQ_REMOVE;
                    send(kind, pool_key[slot], h, $urandom);
                end
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (replies_owed != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
        if (mismatch_count == 0 && replies_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
